/* hdl/mpfd_pkg.sv */
// Shared types, codes and the glyph font table for the page frame-buffer draw unit.
`default_nettype none
package mpfd_pkg;

   // Signed coordinate width for shape corners after glyph offsets are added.
   localparam int COORD_W = 18;
   // Signed size width for box extents.
   localparam int SIZE_W  = 10;

   typedef enum logic [2:0] {
      OP_FILL  = 3'd0,
      OP_HLINE = 3'd1,
      OP_VLINE = 3'd2,
      OP_RECT  = 3'd3,
      OP_GLYPH = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         width;
      logic signed [7:0]  height;
      logic               color;
      logic               bg_color;
      logic [6:0]         char_code;
      logic [7:0]         scale;
      logic [9:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       is_read;
   } rsp_type;

   // One clipped-fill job handed to the box walker.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [SIZE_W-1:0]  w;
      logic signed [SIZE_W-1:0]  h;
      logic                      color;
   } box_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NEXT,
      ST_BOX,
      ST_READ,
      ST_RWAIT,
      ST_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      WS_IDLE,
      WS_SETUP,
      WS_READ,
      WS_WRITE
   } walk_state_type;

   // 6x6 font, column by column, bit 6*col+row.
   function automatic logic [31:0] glyph_rom(input logic [5:0] idx);
      logic [31:0] word;
      unique case (idx)
         6'd0:  word = 32'h00000000;  6'd1:  word = 32'h00017000;
         6'd2:  word = 32'h000C00C0;  6'd3:  word = 32'h0A7CA7CA;
         6'd4:  word = 32'h0A2DE2CA;  6'd5:  word = 32'h19484253;
         6'd6:  word = 32'h1251F55E;  6'd7:  word = 32'h00003000;
         6'd8:  word = 32'h00452700;  6'd9:  word = 32'h001C9440;
         6'd10: word = 32'h0519F314;  6'd11: word = 32'h0411F104;
         6'd12: word = 32'h00000420;  6'd13: word = 32'h04104104;
         6'd14: word = 32'h00000400;  6'd15: word = 32'h01084210;
         6'd16: word = 32'h0F45145E;  6'd17: word = 32'h0001F040;
         6'd18: word = 32'h13555559;  6'd19: word = 32'h0D5D5551;
         6'd20: word = 32'h087C928C;  6'd21: word = 32'h0D555557;
         6'd22: word = 32'h0D55555E;  6'd23: word = 32'h010C5251;
         6'd24: word = 32'h0F55555E;  6'd25: word = 32'h0F555556;
         6'd26: word = 32'h0000A000;  6'd27: word = 32'h0000A400;
         6'd28: word = 32'h0028C200;  6'd29: word = 32'h0028A280;
         6'd30: word = 32'h00086280;  6'd31: word = 32'h000D5040;
         6'd32: word = 32'h0755745E;  6'd33: word = 32'h1F24929C;
         6'd34: word = 32'h0D5D555F;  6'd35: word = 32'h1145149C;
         6'd36: word = 32'h0725145F;  6'd37: word = 32'h1155555F;
         6'd38: word = 32'h0114515F;  6'd39: word = 32'h1D55545E;
         6'd40: word = 32'h1F10411F;  6'd41: word = 32'h0045F440;
         6'd42: word = 32'h07210410;  6'd43: word = 32'h1D18411F;
         6'd44: word = 32'h1041041F;  6'd45: word = 32'h1F04F05E;
         6'd46: word = 32'h1F04109C;  6'd47: word = 32'h0F45545E;
         6'd48: word = 32'h0314925F;  6'd49: word = 32'h1F45D45E;
         6'd50: word = 32'h1B34925F;  6'd51: word = 32'h0D555556;
         6'd52: word = 32'h0105F041;  6'd53: word = 32'h0721041F;
         6'd54: word = 32'h0108421F;  6'd55: word = 32'h0F41E41F;
         6'd56: word = 32'h1D184317;  6'd57: word = 32'h0109C107;
         6'd58: word = 32'h114D5651;  6'd59: word = 32'h0045F000;
         6'd60: word = 32'h0001F000;  6'd61: word = 32'h0001F440;
         6'd62: word = 32'h000C1080;  6'd63: word = 32'h10410410;
         default: word = 32'h00000000;
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

/* hdl/mpfd_fb_mem.sv */
// Single-port frame-buffer byte memory with registered read data.
`default_nettype none
module mpfd_fb_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic          re,
   input  wire logic [AW-1:0] addr,
   input  wire logic [7:0]    wdata,
   output logic      [7:0]    rdata_ff
);
   logic [7:0] mem [DEPTH];

   // At most one write and one read per cycle, both at addr.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end
endmodule
`default_nettype wire

/* hdl/mpfd_box_walker.sv */
// Clips one box to the screen and walks its bytes with read-modify-write.
`default_nettype none
module mpfd_box_walker #(
   parameter int SW = 128,
   parameter int SH = 64,
   parameter int AW = 10
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire mpfd_pkg::box_type box,
   input  wire logic [7:0]      rdata,
   output logic                 done,
   output logic                 mem_we,
   output logic                 mem_re,
   output logic [AW-1:0]        mem_addr,
   output logic [7:0]           mem_wdata
);
   import mpfd_pkg::*;

   localparam int CW = $clog2(SW + 1);
   localparam int RW = $clog2(SH + 1);
   localparam int PW = RW - 3;
   localparam logic signed [COORD_W-1:0] SW_S = COORD_W'(SW);
   localparam logic signed [COORD_W-1:0] SH_S = COORD_W'(SH);

   walk_state_type state_ff, state_in;
   box_type        box_ff, box_in;
   logic [CW-1:0]  col_ff, col_in, col_first_ff, col_first_in, col_last_ff, col_last_in;
   logic [PW-1:0]  page_ff, page_in, page_first_ff, page_first_in;
   logic [PW-1:0]  page_last_ff, page_last_in;
   logic [2:0]     row_lo_ff, row_lo_in, row_hi_ff, row_hi_in;
   logic [AW-1:0]  base_ff, base_in;

   logic signed [COORD_W-1:0] x0, y0, x1, y1, x1c, y1c, x1m, y1m;
   logic [RW-1:0]  y0_row, y1_row;
   logic           empty, last_col, last_page;
   logic [2:0]     lo, hi;
   logic [7:0]     mask;

   // Clip the latched box against the screen.
   always_comb begin
      x0  = box_ff.x < 0 ? '0 : box_ff.x;
      y0  = box_ff.y < 0 ? '0 : box_ff.y;
      x1  = box_ff.x + COORD_W'(box_ff.w);
      y1  = box_ff.y + COORD_W'(box_ff.h);
      x1c = x1 > SW_S ? SW_S : x1;
      y1c = y1 > SH_S ? SH_S : y1;
      x1m = x1c - COORD_W'(1);
      y1m = y1c - COORD_W'(1);
      empty = (box_ff.w <= 0) || (box_ff.h <= 0) || (x0 >= x1c) || (y0 >= y1c);
      y0_row = y0[RW-1:0];
      y1_row = y1m[RW-1:0];
   end

   // Page mask and walk position.
   always_comb begin
      lo        = (page_ff == page_first_ff) ? row_lo_ff : 3'd0;
      hi        = (page_ff == page_last_ff) ? row_hi_ff : 3'd7;
      mask      = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
      last_col  = col_ff == col_last_ff;
      last_page = page_ff == page_last_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WS_IDLE:  if (start) state_in = WS_SETUP;
         WS_SETUP: state_in = empty ? WS_IDLE : WS_READ;
         WS_READ:  state_in = WS_WRITE;
         WS_WRITE: state_in = (last_col && last_page) ? WS_IDLE : WS_READ;
         default:  state_in = WS_IDLE;
      endcase
   end

   // Outputs toward the memory and the sequencer.
   always_comb begin
      mem_addr  = base_ff + AW'(col_ff);
      mem_re    = state_ff == WS_READ;
      mem_we    = state_ff == WS_WRITE;
      mem_wdata = box_ff.color ? (rdata | mask) : (rdata & ~mask);
      done      = ((state_ff == WS_SETUP) && empty) ||
                  ((state_ff == WS_WRITE) && last_col && last_page);
   end

   // Walk registers.
   always_comb begin
      box_in        = box_ff;
      col_in        = col_ff;
      col_first_in  = col_first_ff;
      col_last_in   = col_last_ff;
      page_in       = page_ff;
      page_first_in = page_first_ff;
      page_last_in  = page_last_ff;
      row_lo_in     = row_lo_ff;
      row_hi_in     = row_hi_ff;
      base_in       = base_ff;
      unique case (state_ff)
         WS_IDLE: begin
            if (start) box_in = box;
         end
         WS_SETUP: begin
            col_in        = x0[CW-1:0];
            col_first_in  = x0[CW-1:0];
            col_last_in   = x1m[CW-1:0];
            page_in       = y0_row[RW-1:3];
            page_first_in = y0_row[RW-1:3];
            page_last_in  = y1_row[RW-1:3];
            row_lo_in     = y0_row[2:0];
            row_hi_in     = y1_row[2:0];
            base_in       = AW'(y0_row[RW-1:3]) * AW'(SW);
         end
         WS_WRITE: begin
            if (last_col) begin
               col_in  = col_first_ff;
               page_in = page_ff + PW'(1);
               base_in = base_ff + AW'(SW);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      box_ff        <= box_in;
      col_ff        <= col_in;
      col_first_ff  <= col_first_in;
      col_last_ff   <= col_last_in;
      page_ff       <= page_in;
      page_first_ff <= page_first_in;
      page_last_ff  <= page_last_in;
      row_lo_ff     <= row_lo_in;
      row_hi_ff     <= row_hi_in;
      base_ff       <= base_in;
   end
endmodule
`default_nettype wire

/* hdl/mono_page_framebuffer_draw_unit.sv */
// Top level of the page frame-buffer draw unit: command sequencer and result register.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_data (req_type)
//   rsp     | out       | rsp_valid, rsp_ready, rsp_data (rsp_type)
//
// After reset a clearing pass writes zero to all SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes,
// one byte a cycle, and req_ready stays low meanwhile. Each drawing command is split
// into boxes (1, 4 or 36); the box walker reads and then writes each touched byte on
// the single memory port, after a setup state per box. A read passes through ST_READ
// and ST_RWAIT. The result waits in an output register, so a stalled rsp side does
// not hold back the next command's drawing.
`default_nettype none
module mono_page_framebuffer_draw_unit #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mpfd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mpfd_pkg::rsp_type      rsp_data
);
   import mpfd_pkg::*;

   localparam int FB_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
   localparam int AW       = $clog2(FB_BYTES);

   top_state_type state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [5:0]    idx_ff, idx_in;
   logic [2:0]    gj_ff, gj_in;
   logic [10:0]   gx_ff, gx_in, gy_ff, gy_in;
   logic [31:0]   pat_ff, pat_in;
   logic          rng_ff, rng_in;
   logic [7:0]    rd_ff, rd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          draw_ok, paint, last, advance, dot, load_rsp;
   logic [5:0]    last_idx;
   box_type       box;
   logic          walk_done, w_we, w_re;
   logic [AW-1:0] w_addr, m_addr;
   logic [7:0]    w_wdata, m_wdata, m_rdata;
   logic          m_we, m_re;
   logic signed [COORD_W-1:0] px, py;
   logic signed [SIZE_W-1:0]  sw_, sh_;

   assign px  = COORD_W'(cmd_ff.pos_x);
   assign py  = COORD_W'(cmd_ff.pos_y);
   assign sw_ = SIZE_W'({1'b0, cmd_ff.width});
   assign sh_ = SIZE_W'(cmd_ff.height);

   // Box selection for the current command and box index.
   always_comb begin
      dot      = !idx_ff[5] && pat_ff[idx_ff[4:0]];
      draw_ok  = 1'b1;
      last_idx = 6'd0;
      box      = '{x: px, y: py, w: sw_, h: sh_, color: cmd_ff.color};
      paint    = 1'b1;
      unique case (cmd_ff.opcode)
         OP_FILL: begin
         end
         OP_HLINE: box.h = SIZE_W'(1);
         OP_VLINE: box.w = SIZE_W'(1);
         OP_RECT: begin
            last_idx = 6'd3;
            draw_ok  = sh_ > 0;
            unique case (idx_ff[1:0])
               2'd0: box.h = SIZE_W'(1);
               2'd1: begin
                  box.y = py + COORD_W'(sh_) - COORD_W'(1);
                  box.h = SIZE_W'(1);
               end
               2'd2: begin
                  box.y = py + COORD_W'(1);
                  box.w = SIZE_W'(1);
                  box.h = sh_ - SIZE_W'(2);
               end
               default: begin
                  box.x = px + COORD_W'(sw_) - COORD_W'(1);
                  box.y = py + COORD_W'(1);
                  box.w = SIZE_W'(1);
                  box.h = sh_ - SIZE_W'(2);
               end
            endcase
         end
         OP_GLYPH: begin
            last_idx  = 6'd35;
            box.x     = px + COORD_W'(gx_ff);
            box.y     = py + COORD_W'(gy_ff);
            box.w     = SIZE_W'({1'b0, cmd_ff.scale});
            box.h     = SIZE_W'({1'b0, cmd_ff.scale});
            box.color = dot ? cmd_ff.color : cmd_ff.bg_color;
            paint     = dot || (cmd_ff.color != cmd_ff.bg_color);
         end
         default: draw_ok = 1'b0;
      endcase
      last = idx_ff == last_idx;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(FB_BYTES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.opcode == OP_READ) ? ST_READ : ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (draw_ok && paint) state_in = ST_BOX;
            else if (!draw_ok || last) state_in = ST_DONE;
         end
         ST_BOX:   if (walk_done && last) state_in = ST_DONE;
                   else if (walk_done) state_in = ST_NEXT;
         ST_READ:  state_in = ST_RWAIT;
         ST_RWAIT: state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs and memory port selection.
   always_comb begin
      req_ready = state_ff == ST_IDLE;
      advance   = ((state_ff == ST_NEXT) && draw_ok && !paint && !last) ||
                  ((state_ff == ST_BOX) && walk_done && !last);
      load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      m_we      = w_we;
      m_re      = w_re;
      m_addr    = w_addr;
      m_wdata   = w_wdata;
      unique case (state_ff)
         ST_CLEAR: begin
            m_we    = 1'b1;
            m_re    = 1'b0;
            m_addr  = clr_ff;
            m_wdata = 8'h00;
         end
         ST_READ: begin
            m_we   = 1'b0;
            m_re   = rng_ff;
            m_addr = AW'(cmd_ff.read_index);
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cmd_in       = cmd_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      gj_in        = gj_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      pat_in       = pat_ff;
      rng_in       = rng_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (state_ff == ST_CLEAR) clr_in = clr_ff + AW'(1);
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_in = req_data;
         idx_in = 6'd0;
         gj_in  = 3'd0;
         gx_in  = 11'd0;
         gy_in  = 11'd0;
         pat_in = glyph_rom(req_data.char_code[5:0] - 6'd32);
         rng_in = 32'(req_data.read_index) < FB_BYTES;
         rd_in  = 8'h00;
      end
      if (advance) begin
         idx_in = idx_ff + 6'd1;
         if (gj_ff == 3'd5) begin
            gj_in = 3'd0;
            gy_in = 11'd0;
            gx_in = gx_ff + 11'(cmd_ff.scale);
         end else begin
            gj_in = gj_ff + 3'd1;
            gy_in = gy_ff + 11'(cmd_ff.scale);
         end
      end
      if (state_ff == ST_RWAIT && rng_ff) rd_in = m_rdata;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_in.is_read = cmd_ff.opcode == OP_READ;
         rsp_in.read_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      gj_ff  <= gj_in;
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
      pat_ff <= pat_in;
      rng_ff <= rng_in;
      rd_ff  <= rd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mpfd_box_walker #(
      .SW(SCREEN_WIDTH),
      .SH(SCREEN_HEIGHT),
      .AW(AW)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_NEXT) && draw_ok && paint),
      .box      (box),
      .rdata    (m_rdata),
      .done     (walk_done),
      .mem_we   (w_we),
      .mem_re   (w_re),
      .mem_addr (w_addr),
      .mem_wdata(w_wdata)
   );

   mpfd_fb_mem #(
      .DEPTH(FB_BYTES),
      .AW   (AW)
   ) u_mem (
      .clock   (clock),
      .we      (m_we),
      .re      (m_re),
      .addr    (m_addr),
      .wdata   (m_wdata),
      .rdata_ff(m_rdata)
   );
endmodule
`default_nettype wire

/* hdl/mpfd_checker.sv */
// Port-level checks for the page frame-buffer draw unit, bound to the top level.
`default_nettype none
module mpfd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire mpfd_pkg::rsp_type rsp_data
);
   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // A draw completion carries a zero data byte.
   a_draw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_read |-> rsp_data.read_data == 8'h00)
      else $error("draw result carries nonzero data");

   // The clearing pass keeps the input closed right after reset.
   a_clear_closed: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready)
      else $error("input open during clearing pass");

   // Only one command is in flight at a time.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input stayed open after a command beat");
endmodule

bind mono_page_framebuffer_draw_unit mpfd_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the page frame-buffer draw unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import mpfd_pkg::*;

   localparam int SCR_W    = 128;
   localparam int SCR_H    = 64;
   localparam int FB_SIZE  = SCR_W * ((SCR_H + 7) / 8);
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // Font words, column by column, bit 6*col+row.
   localparam logic [31:0] FONT [64] = '{
      32'h00000000, 32'h00017000, 32'h000C00C0, 32'h0A7CA7CA,
      32'h0A2DE2CA, 32'h19484253, 32'h1251F55E, 32'h00003000,
      32'h00452700, 32'h001C9440, 32'h0519F314, 32'h0411F104,
      32'h00000420, 32'h04104104, 32'h00000400, 32'h01084210,
      32'h0F45145E, 32'h0001F040, 32'h13555559, 32'h0D5D5551,
      32'h087C928C, 32'h0D555557, 32'h0D55555E, 32'h010C5251,
      32'h0F55555E, 32'h0F555556, 32'h0000A000, 32'h0000A400,
      32'h0028C200, 32'h0028A280, 32'h00086280, 32'h000D5040,
      32'h0755745E, 32'h1F24929C, 32'h0D5D555F, 32'h1145149C,
      32'h0725145F, 32'h1155555F, 32'h0114515F, 32'h1D55545E,
      32'h1F10411F, 32'h0045F440, 32'h07210410, 32'h1D18411F,
      32'h1041041F, 32'h1F04F05E, 32'h1F04109C, 32'h0F45545E,
      32'h0314925F, 32'h1F45D45E, 32'h1B34925F, 32'h0D555556,
      32'h0105F041, 32'h0721041F, 32'h0108421F, 32'h0F41E41F,
      32'h1D184317, 32'h0109C107, 32'h114D5651, 32'h0045F000,
      32'h0001F000, 32'h0001F440, 32'h000C1080, 32'h10410410
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the screen and the queue of results still owed.
   logic [7:0] shadow_fb [FB_SIZE];
   rsp_type    pending_rsp [$];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         error_count = 0;
   int         beats_sent = 0;
   int         reads_checked = 0;
   int         draws_checked = 0;

   mono_page_framebuffer_draw_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Clipped box paint on the shadow screen.
   task automatic shade_box(input int x, input int y, input int w, input int h,
                            input logic c);
      int x0, y0, x1, y1;
      int idx;
      if (w <= 0 || h <= 0) return;
      x0 = (x < 0) ? 0 : x;
      y0 = (y < 0) ? 0 : y;
      x1 = (x + w > SCR_W) ? SCR_W : x + w;
      y1 = (y + h > SCR_H) ? SCR_H : y + h;
      for (int r = y0; r < y1; r++) begin
         for (int col = x0; col < x1; col++) begin
            idx = (r >> 3) * SCR_W + col;
            shadow_fb[idx][r & 7] = c;
         end
      end
   endtask

   // Apply one accepted command to the shadow screen and queue its result.
   task automatic apply_command(input req_type cmd);
      int x, y, w, h, s;
      logic [31:0] pat;
      logic dot;
      rsp_type res;
      x = int'(cmd.pos_x);
      y = int'(cmd.pos_y);
      w = int'(cmd.width);
      h = int'(cmd.height);
      s = int'(cmd.scale);
      res = '0;
      case (cmd.opcode)
         OP_FILL:  shade_box(x, y, w, h, cmd.color);
         OP_HLINE: shade_box(x, y, w, 1, cmd.color);
         OP_VLINE: shade_box(x, y, 1, h, cmd.color);
         OP_RECT: begin
            if (h > 0) begin
               shade_box(x, y, w, 1, cmd.color);
               shade_box(x, y + h - 1, w, 1, cmd.color);
               shade_box(x, y + 1, 1, h - 2, cmd.color);
               shade_box(x + w - 1, y + 1, 1, h - 2, cmd.color);
            end
         end
         OP_GLYPH: begin
            pat = FONT[6'(cmd.char_code - 7'd32)];
            for (int i = 0; i < 6; i++) begin
               for (int j = 0; j < 6; j++) begin
                  dot = (i * 6 + j < 32) ? pat[i * 6 + j] : 1'b0;
                  if (dot || cmd.bg_color != cmd.color)
                     shade_box(x + i * s, y + j * s, s, s, dot ? cmd.color : cmd.bg_color);
               end
            end
         end
         OP_READ: begin
            res.read_data = (cmd.read_index < FB_SIZE) ? shadow_fb[cmd.read_index] : 8'h00;
            res.is_read = 1'b1;
         end
         default: ;
      endcase
      pending_rsp.push_back(res);
   endtask

   // Send one command beat and record its expected result on acceptance.
   task automatic send_beat(input req_type cmd);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_data = cmd;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      apply_command(cmd);
      beats_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_cmd(input logic [2:0] op, input int x, input int y, input int w,
                           input int h, input logic c, input logic bg, input int ch,
                           input int s, input int ri);
      req_type cmd;
      cmd.opcode = op;
      cmd.pos_x = 16'(x);
      cmd.pos_y = 16'(y);
      cmd.width = 8'(w);
      cmd.height = 8'(h);
      cmd.color = c;
      cmd.bg_color = bg;
      cmd.char_code = 7'(ch);
      cmd.scale = 8'(s);
      cmd.read_index = 10'(ri);
      send_beat(cmd);
   endtask

   task automatic read_byte(input int ri);
      send_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
               1'($urandom), $urandom, $urandom, ri);
   endtask

   // Receiver: random stalls on the result side.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare every result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.is_read !== want.is_read) begin
               $display("%0t: is_read mismatch, expected %b actual %b",
                        $time, want.is_read, rsp_data.is_read);
               error_count++;
            end
            if (rsp_data.read_data !== want.read_data) begin
               $display("%0t: read_data mismatch, expected %h actual %h",
                        $time, want.read_data, rsp_data.read_data);
               error_count++;
            end
            if (want.is_read) reads_checked++;
            else draws_checked++;
         end
      end
   end

   // Extremes, every opcode and the documented corner cases.
   task automatic test_directed();
      read_byte(0);
      read_byte(FB_SIZE - 1);
      send_cmd(OP_FILL, 0, 0, 255, 127, 1'b1, 1'b0, 32, 1, 0);
      read_byte(FB_SIZE - 1);
      send_cmd(OP_FILL, -32768, -32768, 255, 127, 1'b0, 1'b0, 32, 1, 0);
      send_cmd(OP_FILL, 32767, 32767, 255, 127, 1'b0, 1'b0, 32, 1, 0);
      send_cmd(OP_HLINE, -5, 3, 20, -128, 1'b0, 1'b1, 32, 1, 0);
      send_cmd(OP_VLINE, 127, 60, 0, 0, 1'b0, 1'b0, 32, 1, 0);
      send_cmd(OP_VLINE, 10, -3, 0, 40, 1'b0, 1'b0, 32, 1, 0);
      read_byte(10);
      send_cmd(OP_RECT, 20, 8, 0, 10, 1'b0, 1'b0, 32, 1, 0);
      send_cmd(OP_RECT, 40, 9, 30, 1, 1'b0, 1'b0, 32, 1, 0);
      send_cmd(OP_RECT, 50, 20, 10, -1, 1'b0, 1'b0, 32, 1, 0);
      read_byte(SCR_W + 19);
      read_byte(SCR_W + 20);
      send_cmd(OP_FILL, 0, 0, 128, 64, 1'b0, 1'b0, 32, 1, 0);
      send_cmd(OP_GLYPH, 2, 3, 0, 0, 1'b1, 1'b1, 65, 1, 0);
      send_cmd(OP_GLYPH, 10, 5, 0, 0, 1'b1, 1'b0, 0, 2, 0);
      send_cmd(OP_GLYPH, 120, 60, 0, 0, 1'b1, 1'b0, 127, 3, 0);
      send_cmd(OP_GLYPH, 30, 30, 0, 0, 1'b1, 1'b0, 66, 0, 0);
      read_byte(0);
      read_byte(SCR_W + 10);
      send_cmd(OP_SPARE_6, -1, -1, 255, -1, 1'b1, 1'b1, 127, 255, 1023);
      send_cmd(OP_SPARE_7, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0);
      read_byte(FB_SIZE - 1);
   endtask

   // Random commands, mostly near the screen with small glyph scales.
   task automatic test_random(input int count, input int s_idle, input int r_idle);
      int pick;
      int x, y, s;
      logic [2:0] op;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 30) op = OP_READ;
         else if (pick < 45) op = OP_FILL;
         else if (pick < 55) op = OP_HLINE;
         else if (pick < 65) op = OP_VLINE;
         else if (pick < 75) op = OP_RECT;
         else if (pick < 97) op = OP_GLYPH;
         else op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
         if ($urandom_range(19) == 0) begin
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
         end else begin
            x = $urandom_range(SCR_W + 40) - 30;
            y = $urandom_range(SCR_H + 40) - 30;
         end
         s = ($urandom_range(49) == 0) ? $urandom_range(255) : $urandom_range(4);
         if (op == OP_READ)
            read_byte($urandom_range(FB_SIZE - 1));
         else
            send_cmd(op, x, y, $urandom_range(255), $signed(8'($urandom)), 1'($urandom),
                     1'($urandom), ($urandom_range(9) == 0) ? $urandom_range(127)
                     : $urandom_range(95, 32), s, $urandom);
      end
   endtask

   initial begin
      // The screen starts out cleared.
      foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(500, 11, 63);
      test_random(500, 63, 11);
      test_random(500, 0, 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (pending_rsp.size() == 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d commands; checked %0d draw completions and %0d byte reads.",
               beats_sent, draws_checked, reads_checked);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #250ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
hdl/mpfd_pkg.sv
hdl/mpfd_fb_mem.sv
hdl/mpfd_box_walker.sv
hdl/mono_page_framebuffer_draw_unit.sv
hdl/mpfd_checker.sv
tb/tb_top.sv
